// ===== rtl/bpdq_pkg.sv =====
// Shared types and constants for the box point depth query block.
`timescale 1ns / 1ps

package bpdq_pkg;

  // Default parameter values
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_COORD_WIDTH = 32;

  // Register and result widths
  localparam int CFG_WIDTH     = 31;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int DEPTH_WIDTH   = 34;

  localparam logic [CFG_WIDTH-1:0] TOL_RESET = CFG_WIDTH'(66);

  // Register map
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_SIDE_X   = 2'd0,
    CFG_SIDE_Y   = 2'd1,
    CFG_SIDE_Z   = 2'd2,
    CFG_SURF_TOL = 2'd3
  } cfg_idx_t;

  // Per-request status carried alongside the square root pipeline
  typedef struct packed {
    logic                 in_box;
    logic                 surf;
    logic                 outside;
    logic [CFG_WIDTH-1:0] min_depth;
  } qry_tag_t;

endpackage

// ===== rtl/bpdq_isqrt.sv =====
// Pipelined floor square root, one root bit per register stage.
`timescale 1ns / 1ps

module bpdq_isqrt #(
  parameter int RW = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic [2*RW-1:0]       in_rad,
  input  bpdq_pkg::qry_tag_t    in_tag,
  output logic                  out_vld,
  output logic [RW-1:0]         out_root,
  output bpdq_pkg::qry_tag_t    out_tag
);
  import bpdq_pkg::*;

  // Stage registers
  logic              vld_r  [RW];
  logic [RW-1:0]     root_r [RW];
  logic [RW-1:0]     rem_r  [RW];
  logic [2*RW-1:0]   rad_r  [RW];
  qry_tag_t          tag_r  [RW];

  // Stage inputs and next values
  logic [RW-1:0]     root_in  [RW];
  logic [RW-1:0]     rem_in   [RW];
  logic [2*RW-1:0]   rad_in   [RW];
  logic [RW+1:0]     rem2_c   [RW];
  logic [RW+1:0]     trial_c  [RW];
  logic [RW-1:0]     root_nxt [RW];
  logic [RW-1:0]     rem_nxt  [RW];
  logic [2*RW-1:0]   rad_nxt  [RW];

  // Route the previous stage into each stage
  always_comb begin
    root_in[0] = '0;
    rem_in[0]  = '0;
    rad_in[0]  = in_rad;
    for (int k = 1; k < RW; k++) begin
      root_in[k] = root_r[k-1];
      rem_in[k]  = rem_r[k-1];
      rad_in[k]  = rad_r[k-1];
    end
  end

  // One restoring step per stage: bring down two radicand bits, try 4*root+1
  always_comb begin
    for (int k = 0; k < RW; k++) begin
      rem2_c[k]  = {rem_in[k], rad_in[k][2*RW-1 -: 2]};
      trial_c[k] = {root_in[k], 2'b01};
      if (rem2_c[k] >= trial_c[k]) begin
        rem_nxt[k]  = RW'(rem2_c[k] - trial_c[k]);
        root_nxt[k] = {root_in[k][RW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem2_c[k][RW-1:0];
        root_nxt[k] = {root_in[k][RW-2:0], 1'b0};
      end
      rad_nxt[k] = rad_in[k] << 2;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < RW; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < RW; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Data
  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    for (int k = 1; k < RW; k++) tag_r[k] <= tag_r[k-1];
    for (int k = 0; k < RW; k++) begin
      root_r[k] <= root_nxt[k];
      rem_r[k]  <= rem_nxt[k];
      rad_r[k]  <= rad_nxt[k];
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_tag  = tag_r[RW-1];

endmodule

// ===== rtl/box_point_depth_query_core.sv =====
// Box point depth query: inside / on-surface tests and signed depth per point.
// Structure: COORD_WIDTH+6 register stages (38 at 32-bit coordinates): five front stages,
//   one stage per root bit in the square root pipeline, and the output register.
// Throughput: one request per cycle, busy is low whenever reset is released, and the
//   receiver cannot stall. Reset clears all valid bits, loads unit sides and tolerance 66.
`timescale 1ns / 1ps

module box_point_depth_query_core #(
  parameter int FRAC_BITS   = bpdq_pkg::DEF_FRAC_BITS,
  parameter int COORD_WIDTH = bpdq_pkg::DEF_COORD_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [COORD_WIDTH-1:0]          in_point_x,
  input  logic signed [COORD_WIDTH-1:0]          in_point_y,
  input  logic signed [COORD_WIDTH-1:0]          in_point_z,
  output logic                                   out_strobe,
  output logic                                   out_inside_res,
  output logic                                   out_on_surface,
  output logic signed [bpdq_pkg::DEPTH_WIDTH-1:0] out_depth,
  input  logic                                   cfg_we,
  input  logic [bpdq_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
  input  logic [bpdq_pkg::CFG_WIDTH-1:0]         cfg_wdata
);
  import bpdq_pkg::*;

  localparam int AW   = COORD_WIDTH - 1;                        // magnitude
  localparam int HW   = CFG_WIDTH - 1;                          // half length
  localparam int DW   = ((AW > HW) ? AW : HW) + 1;              // signed a - h
  localparam int LW   = ((AW > CFG_WIDTH) ? AW : CFG_WIDTH) + 1;
  localparam int LOW  = (AW + 1) / 2;                           // split multiply
  localparam int HIW  = AW - LOW;
  localparam int SQW  = 2 * AW;
  localparam int RW   = AW + 1;                                 // root bits
  localparam int SW   = 2 * RW;                                 // radicand bits
  localparam int EW   = (RW + 1 > DEPTH_WIDTH) ? RW + 1 : DEPTH_WIDTH;
  localparam int LAT  = RW + 6;

  localparam logic [CFG_WIDTH-1:0] SIDE_RESET = CFG_WIDTH'(1) << FRAC_BITS;

  // Configuration registers
  logic [CFG_WIDTH-1:0] side_r [3];
  logic [CFG_WIDTH-1:0] tol_r;
  logic [HW-1:0]        half_c [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) side_r[i] <= SIDE_RESET;
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SIDE_X:   side_r[0] <= cfg_wdata;
        CFG_SIDE_Y:   side_r[1] <= cfg_wdata;
        CFG_SIDE_Z:   side_r[2] <= cfg_wdata;
        CFG_SURF_TOL: tol_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) half_c[i] = side_r[i][CFG_WIDTH-1:1];
  end

  assign busy = ~rst_n;

  // Pipeline registers
  logic                  s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic [AW-1:0]         a_r      [3];
  logic signed [DW-1:0]  d_r      [3];
  logic                  lt2_r    [3];
  logic                  lt3_r    [3];
  logic                  gle_r    [3];
  logic [CFG_WIDTH-1:0]  nd_r     [3];
  logic [2*LOW-1:0]      pll_r    [3];
  logic [HIW+LOW-1:0]    phl_r    [3];
  logic [2*HIW-1:0]      phh_r    [3];
  logic                  in3_r, out3_r;
  logic [SQW-1:0]        sq_r     [3];
  qry_tag_t              tag4_r, tag5_r;
  logic [SW-1:0]         sum_r;

  // Next values
  logic signed [COORD_WIDTH-1:0] pt_c [3];
  logic [AW-1:0]         a_nxt    [3];
  logic signed [DW-1:0]  d_nxt    [3];
  logic                  lt_nxt   [3];
  logic [DW-1:0]         gap_c    [3];
  logic [DW-1:0]         ndw_c    [3];
  logic [AW-1:0]         op_c     [3];
  logic                  gle_nxt  [3];
  logic [CFG_WIDTH-1:0]  nd_nxt   [3];
  logic [2*LOW-1:0]      pll_nxt  [3];
  logic [HIW+LOW-1:0]    phl_nxt  [3];
  logic [2*HIW-1:0]      phh_nxt  [3];
  logic                  in3_nxt, out3_nxt;
  logic [SQW-1:0]        sq_nxt   [3];
  qry_tag_t              tag4_nxt, tag5_nxt;
  logic [SW-1:0]         sum_nxt;

  // Stage 1: saturating magnitude of each coordinate
  always_comb begin
    pt_c[0] = in_point_x;
    pt_c[1] = in_point_y;
    pt_c[2] = in_point_z;
    for (int i = 0; i < 3; i++) begin
      if (!pt_c[i][COORD_WIDTH-1]) begin
        a_nxt[i] = pt_c[i][AW-1:0];
      end else if (pt_c[i][AW-1:0] == '0) begin
        a_nxt[i] = '1;
      end else begin
        a_nxt[i] = AW'(-pt_c[i]);
      end
    end
  end

  // Stage 2: distance past each face, and the strict band test
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_nxt[i]  = DW'(a_r[i]) - DW'(half_c[i]);
      lt_nxt[i] = LW'(a_r[i]) < (LW'(half_c[i]) + LW'(tol_r));
    end
  end

  // Stage 3: tolerance test, inside/outside, partial products of d^2
  always_comb begin
    in3_nxt  = 1'b1;
    out3_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ndw_c[i]   = DW'(-d_r[i]);
      gap_c[i]   = d_r[i][DW-1] ? ndw_c[i] : DW'(d_r[i]);
      gle_nxt[i] = gap_c[i] <= DW'(tol_r);
      nd_nxt[i]  = ndw_c[i][CFG_WIDTH-1:0];
      op_c[i]    = d_r[i][DW-1] ? '0 : d_r[i][AW-1:0];
      pll_nxt[i] = op_c[i][LOW-1:0] * op_c[i][LOW-1:0];
      phl_nxt[i] = op_c[i][AW-1:LOW] * op_c[i][LOW-1:0];
      phh_nxt[i] = op_c[i][AW-1:LOW] * op_c[i][AW-1:LOW];
      if (!d_r[i][DW-1] && d_r[i] != '0) in3_nxt = 1'b0;
      if (!d_r[i][DW-1]) out3_nxt = 1'b1;
    end
  end

  // Stage 4: assemble squares, surface test, nearest face inside
  always_comb begin
    tag4_nxt.in_box    = in3_r;
    tag4_nxt.outside   = out3_r;
    tag4_nxt.surf      = 1'b0;
    tag4_nxt.min_depth = nd_r[0];
    if (nd_r[1] < tag4_nxt.min_depth) tag4_nxt.min_depth = nd_r[1];
    if (nd_r[2] < tag4_nxt.min_depth) tag4_nxt.min_depth = nd_r[2];
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = (SQW'(phh_r[i]) << (2 * LOW)) + (SQW'(phl_r[i]) << (LOW + 1))
                + SQW'(pll_r[i]);
      if (gle_r[i] && lt3_r[(i + 1) % 3] && lt3_r[(i + 2) % 3]) tag4_nxt.surf = 1'b1;
    end
  end

  // Stage 5: sum of squares
  always_comb begin
    sum_nxt  = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
    tag5_nxt = tag4_r;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  // Front stage data
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a_r[i]   <= a_nxt[i];
      d_r[i]   <= d_nxt[i];
      lt2_r[i] <= lt_nxt[i];
      lt3_r[i] <= lt2_r[i];
      gle_r[i] <= gle_nxt[i];
      nd_r[i]  <= nd_nxt[i];
      pll_r[i] <= pll_nxt[i];
      phl_r[i] <= phl_nxt[i];
      phh_r[i] <= phh_nxt[i];
      sq_r[i]  <= sq_nxt[i];
    end
    in3_r  <= in3_nxt;
    out3_r <= out3_nxt;
    tag4_r <= tag4_nxt;
    tag5_r <= tag5_nxt;
    sum_r  <= sum_nxt;
  end

  // Square root of the outside distance
  logic          sq_vld;
  logic [RW-1:0] sq_root;
  qry_tag_t      sq_tag;

  bpdq_isqrt #(
    .RW (RW)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s5_vld_r),
    .in_rad   (sum_r),
    .in_tag   (tag5_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  // Output register
  logic                          out_strobe_r, out_strobe_nxt;
  logic                          out_inside_r, out_surf_r;
  logic [DEPTH_WIDTH-1:0]        out_depth_r, out_depth_nxt;
  logic [EW-1:0]                 neg_root_c;

  always_comb begin
    out_strobe_nxt = sq_vld;
    neg_root_c     = EW'(0) - EW'(sq_root);
    out_depth_nxt  = sq_tag.outside ? neg_root_c[DEPTH_WIDTH-1:0]
                                    : DEPTH_WIDTH'(sq_tag.min_depth);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_inside_r <= sq_tag.in_box;
    out_surf_r   <= sq_tag.surf;
    out_depth_r  <= out_depth_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_inside_res = out_inside_r;
  assign out_on_surface = out_surf_r;
  assign out_depth      = out_depth_r;

  // A point inside or on the box never has negative depth
  a_inside_nonneg : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_inside_res) |-> !out_depth[DEPTH_WIDTH-1])
    else $error("inside result with negative depth");

  // A point past some face always has strictly negative depth
  a_outside_neg : assert property (@(posedge clk) disable iff (!rst_n)
    ((RW <= DEPTH_WIDTH - 1) && out_strobe && !out_inside_res)
      |-> out_depth[DEPTH_WIDTH-1])
    else $error("outside result without negative depth");

  // Every result traces back to an earlier accepted request
  a_result_has_request : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LAT))
    else $error("result strobe without matching request");

endmodule

// ===== tb/sv/tb_box_point_depth_query_core.sv =====
// Self-checking testbench for the box point depth query core.
`timescale 1ns / 1ps

module tb_box_point_depth_query_core;
  import bpdq_pkg::*;

  localparam longint COORD_MIN = -64'sd2147483648;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam int     NUM_PHASES = 8;
  localparam int     PHASE_REQS = 179;
  localparam int     MAX_REPORTS = 10;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_req_t;

  typedef struct {
    logic                          in_box;
    logic                          on_surf;
    logic signed [DEPTH_WIDTH-1:0] depth;
  } query_result_t;

  typedef enum {AX_WITHIN, AX_FACE, AX_WILD} axis_kind_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic signed [31:0] in_point_z = '0;
  logic out_strobe;
  logic out_inside_res;
  logic out_on_surface;
  logic signed [DEPTH_WIDTH-1:0] out_depth;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_wdata = '0;

  // Box settings as the core should currently hold them
  logic [CFG_WIDTH-1:0] side_len[3] = '{CFG_WIDTH'(65536), CFG_WIDTH'(65536),
                                        CFG_WIDTH'(65536)};
  logic [CFG_WIDTH-1:0] surf_tol = TOL_RESET;

  point_req_t    pending_points[$];
  query_result_t expected_results[$];
  point_req_t    cur_point;
  int            n_queued = 0;
  int            n_accepted = 0;
  int            n_errs = 0;
  int            idle_pct = 0;

  box_point_depth_query_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .out_strobe     (out_strobe),
    .out_inside_res (out_inside_res),
    .out_on_surface (out_on_surface),
    .out_depth      (out_depth),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Floor square root of a 64-bit sum, one root bit per pass
  function automatic logic [31:0] floor_sqrt(logic [63:0] n);
    logic [65:0] rem;
    logic [65:0] trial;
    logic [31:0] root;
    rem = '0;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      rem = {rem[63:0], n[2*i+1 -: 2]};
      trial = {32'd0, root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = {root[30:0], 1'b1};
      end else begin
        root = {root[30:0], 1'b0};
      end
    end
    return root;
  endfunction

  // Inside / on-surface flags and signed depth of one point
  function automatic query_result_t box_depth_of(point_req_t p);
    longint coord[3];
    longint mag[3];
    longint half[3];
    longint over[3];
    longint tol;
    longint gap;
    longint nearest;
    logic [63:0] sumsq;
    logic beyond;
    int j;
    int k;
    query_result_t r;
    coord[0] = p.x;
    coord[1] = p.y;
    coord[2] = p.z;
    tol = longint'(surf_tol);
    r.in_box = 1'b1;
    r.on_surf = 1'b0;
    beyond = 1'b0;
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      half[i] = longint'(side_len[i] >> 1);
      // most negative coordinate saturates
      if (coord[i] == COORD_MIN) mag[i] = COORD_MAX;
      else mag[i] = (coord[i] < 0) ? -coord[i] : coord[i];
      over[i] = mag[i] - half[i];
      if (mag[i] > half[i]) r.in_box = 1'b0;
      if (over[i] >= 0) begin
        beyond = 1'b1;
        sumsq += 64'(over[i] * over[i]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      gap = half[i] - mag[i];
      if (gap < 0) gap = -gap;
      if (gap <= tol && mag[j] < half[j] + tol && mag[k] < half[k] + tol)
        r.on_surf = 1'b1;
    end
    // on a face counts as outside, so depth there is zero
    if (beyond) begin
      r.depth = DEPTH_WIDTH'(-longint'(floor_sqrt(sumsq)));
    end else begin
      nearest = -over[0];
      if (-over[1] < nearest) nearest = -over[1];
      if (-over[2] < nearest) nearest = -over[2];
      r.depth = DEPTH_WIDTH'(nearest);
    end
    return r;
  endfunction

  // One coordinate of the chosen kind relative to a half length
  function automatic logic signed [31:0] pick_coord(axis_kind_t kind, longint half,
                                                    longint tol);
    longint mag;
    longint band;
    mag = 0;
    case (kind)
      AX_WITHIN: mag = longint'($urandom_range(32'(half)));
      AX_FACE: begin
        band = tol + 4;
        if (band > 64'd16777216) band = 64'd16777216;
        mag = half + longint'($urandom_range(32'(2 * band))) - band;
      end
      AX_WILD: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          default: return $urandom;
        endcase
      end
      default: mag = 0;
    endcase
    if (mag < 0) mag = 0;
    if (mag > COORD_MAX) mag = COORD_MAX;
    if ($urandom_range(1)) mag = -mag;
    return 32'(mag);
  endfunction

  function automatic axis_kind_t wild_axis_kind();
    case ($urandom_range(3))
      0, 1: return AX_WILD;
      2: return AX_FACE;
      default: return AX_WITHIN;
    endcase
  endfunction

  function automatic logic [CFG_WIDTH-1:0] pick_side();
    case ($urandom_range(2))
      0: return CFG_WIDTH'($urandom_range(32'd262144, 32'd1));
      1: return CFG_WIDTH'($urandom_range(32'd16777216, 32'd65536));
      default: return CFG_WIDTH'($urandom_range(32'h7FFF_FFFF, 32'h0100_0000));
    endcase
  endfunction

  function automatic logic [CFG_WIDTH-1:0] pick_tol();
    case ($urandom_range(5))
      0: return '0;
      1: return CFG_WIDTH'($urandom_range(32'h7FFF_FFFF));
      default: return CFG_WIDTH'($urandom_range(32'd1024));
    endcase
  endfunction

  task automatic add_point(logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z);
    point_req_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    pending_points.push_back(p);
    n_queued++;
  endtask

  // Random point: mostly near or inside the box, some anywhere
  task automatic add_random_point();
    axis_kind_t kind[3];
    longint tol;
    int sel;
    int face_axis;
    sel = $urandom_range(99);
    face_axis = $urandom_range(2);
    tol = longint'(surf_tol);
    for (int i = 0; i < 3; i++) begin
      if (sel < 25) kind[i] = AX_WITHIN;
      else if (sel < 60) kind[i] = (i == face_axis || $urandom_range(4) == 0) ?
                                   AX_FACE : AX_WITHIN;
      else if (sel < 75) kind[i] = AX_FACE;
      else kind[i] = wild_axis_kind();
    end
    add_point(pick_coord(kind[0], longint'(side_len[0] >> 1), tol),
              pick_coord(kind[1], longint'(side_len[1] >> 1), tol),
              pick_coord(kind[2], longint'(side_len[2] >> 1), tol));
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_WIDTH-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SIDE_X: side_len[0] = val;
      CFG_SIDE_Y: side_len[1] = val;
      CFG_SIDE_Z: side_len[2] = val;
      CFG_SURF_TOL: surf_tol = val;
      default: ;
    endcase
  endtask

  task automatic set_box(logic [CFG_WIDTH-1:0] sx, logic [CFG_WIDTH-1:0] sy,
                         logic [CFG_WIDTH-1:0] sz, logic [CFG_WIDTH-1:0] tol);
    write_reg(CFG_SIDE_X, sx);
    write_reg(CFG_SIDE_Y, sy);
    write_reg(CFG_SIDE_Z, sz);
    write_reg(CFG_SURF_TOL, tol);
  endtask

  // Wait until every queued request is accepted and answered
  task automatic wait_drained();
    do @(posedge clk);
    while (n_accepted != n_queued || expected_results.size() != 0);
  endtask

  // Request driver: holds start until the core takes the point
  always @(posedge clk) begin : drive_proc
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(box_depth_of(cur_point));
        n_accepted++;
      end
      if (!start || !busy) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_point = pending_points.pop_front();
          start <= 1'b1;
          in_point_x <= cur_point.x;
          in_point_y <= cur_point.y;
          in_point_z <= cur_point.z;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : check_proc
    query_result_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        n_errs++;
        if (n_errs <= MAX_REPORTS)
          $display("ERROR: result with none pending: inside=%0b surf=%0b depth=%0d",
                   out_inside_res, out_on_surface, out_depth);
      end else begin
        want = expected_results.pop_front();
        if (out_inside_res !== want.in_box || out_on_surface !== want.on_surf ||
            out_depth !== want.depth) begin
          n_errs++;
          if (n_errs <= MAX_REPORTS)
            $display("ERROR: inside exp %0b got %0b, surf exp %0b got %0b, %s%0d got %0d",
                     want.in_box, out_inside_res, want.on_surf, out_on_surface,
                     "depth exp ", want.depth, out_depth);
        end
      end
    end
  end

  // Stimulus and phase control
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed points at reset settings: half length 32768, tolerance 66
    idle_pct = 0;
    add_point(0, 0, 0);
    add_point(32768, 0, 0);
    add_point(0, -32768, 0);
    add_point(0, 0, 32768 + 66);
    add_point(32768 + 67, 0, 0);
    add_point(0, 32768 - 66, 0);
    add_point(0, 0, -(32768 - 67));
    add_point(0, 32768 + 1000, 0);
    add_point(32768, 32768, 32768);
    add_point(32768 + 65, 32768 + 65, 0);
    add_point(32768 + 66, 32768 + 66, 0);
    add_point(-32767, 32767, -32767);
    add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    add_point(32'sh8000_0000, 0, 32'sh7FFF_FFFF);
    add_point(32'sh8000_0001, 1, -1);
    add_point(-1, 32'sh5555_5555, 32'shAAAA_AAAA);
    add_point(40000, 50000, 60000);
    add_point(0, 0, 32'sh7FFF_FFFF);
    add_point(1, 2, 3);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) set_box(CFG_WIDTH'(32'h7FFF_FFFF), CFG_WIDTH'(32'h7FFF_FFFF),
                           CFG_WIDTH'(32'h7FFF_FFFF), '0);
      else if (ph == 1) set_box(CFG_WIDTH'(1), CFG_WIDTH'(1), CFG_WIDTH'(1),
                                CFG_WIDTH'(32'h7FFF_FFFF));
      else set_box(pick_side(), pick_side(), pick_side(), pick_tol());
      // sender gaps: light, then heavy, then none
      if (ph < 3) idle_pct = 13;
      else if (ph < 6) idle_pct = 56;
      else idle_pct = 0;
      for (int n = 0; n < PHASE_REQS; n++) add_random_point();
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (n_errs == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
